// ===== rtl/sorted_sixteen_entry_key_table_defines.svh =====
// Assertion macros shared by the checker of the sorted key table.
// Depends on nothing; included by the checker file.
`ifndef SORTED_SIXTEEN_ENTRY_KEY_TABLE_DEFINES_SVH
`define SORTED_SIXTEEN_ENTRY_KEY_TABLE_DEFINES_SVH

// Condition holds, so the consequence holds in the same cycle.
`define SSTKT_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("sorted key table check failed");

// Condition holds, so the consequence holds in the next cycle.
`define SSTKT_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("sorted key table check failed");

`endif

// ===== rtl/sstkt_pkg.sv =====
// Package of the sorted key table: sizes, operation and status codes, cell structs.
// Depends on nothing; used by every module of the block.
`default_nettype none

package sstkt_pkg;

    localparam int ENTRIES         = 16;
    localparam int COUNT_W         = $clog2(ENTRIES + 1);
    localparam int KEY_W           = 8;
    localparam int CHILD_W         = 64;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 2;
    localparam int UNDERFULL_COUNT = 3;

    // Input transfer layout, lowest bit first.
    localparam int IN_BITS   = OP_W + KEY_W + CHILD_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    // Result transfer layout, lowest bit first.
    localparam int OUT_BITS   = CHILD_W + 1 + STATUS_W + COUNT_W + 1 + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Per-cell control from the top level.
    typedef struct packed {
        logic               ins_en;
        logic               chg_en;
        logic               valid;
        logic               at_tail;
        logic [KEY_W-1:0]   key;
        logic [CHILD_W-1:0] value;
    } cell_ctrl_t;

    // What one cell hands to its right-hand neighbor.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CHILD_W-1:0] child;
        logic               shift;
        logic               hit;
        logic [CHILD_W-1:0] hit_child;
    } link_t;

endpackage

`default_nettype wire

// ===== rtl/sstkt_cell.sv =====
// One slot of the sorted key table: key and child registers, compare and shift logic.
// Depends on sstkt_pkg.
`default_nettype none

module sstkt_cell
    import sstkt_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire link_t      lin,
    output link_t           lout
);

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [CHILD_W-1:0] child_reg;
    logic [CHILD_W-1:0] child_next;
    logic               match;
    logic               first;
    logic               shift;

    // Compare the slot against the requested key.
    assign match = ctrl.valid && (key_reg == ctrl.key);
    assign first = match && !lin.hit;
    assign shift = ctrl.valid && (key_reg > ctrl.key);

    // Hand the slot contents and the search chain to the right.
    assign lout.key       = key_reg;
    assign lout.child     = child_reg;
    assign lout.shift     = shift;
    assign lout.hit       = lin.hit || match;
    assign lout.hit_child = first ? child_reg : lin.hit_child;

    // Insert moves the slot up or loads the new entry; change rewrites the first match.
    always_comb
    begin
        key_next   = key_reg;
        child_next = child_reg;
        if (ctrl.ins_en)
        begin
            if (lin.shift)
            begin
                key_next   = lin.key;
                child_next = lin.child;
            end
            else if (shift || ctrl.at_tail)
            begin
                key_next   = ctrl.key;
                child_next = ctrl.value;
            end
        end
        else if (ctrl.chg_en && first)
        begin
            child_next = ctrl.value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        child_reg <= child_next;
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_sixteen_entry_key_table.sv =====
// Sorted table of sixteen entries (key byte, 64-bit child) kept in ascending unsigned key
// order in a row of slot cells. For each input transfer (insert, lookup or change), all slots
// compare against the key at once, a search chain across the row picks the first match, and
// an insert moves every larger entry up one slot in the same edge. The result appears in an
// output register in the cycle after acceptance, and a new item is taken whenever that
// register is empty or being read, so the block sustains one item per cycle while the
// result side keeps up.
// Depends on sstkt_pkg and sstkt_cell.
`default_nettype none

module sorted_sixteen_entry_key_table
    import sstkt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // s_tdata fields from bit 0: op (2), key (8), child_value (64), zero fill.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // m_tdata fields from bit 0: found_child (64), found (1), status (2),
    // entry_count (5), is_full (1), is_underfull (1), zero fill.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic                  accept;
    logic [OP_W-1:0]       op;
    logic [KEY_W-1:0]      key;
    logic [CHILD_W-1:0]    child_value;
    logic                  full;
    logic                  ins_en;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_BITS-1:0]   out_data_reg;
    logic [OUT_BITS-1:0]   out_data_next;
    logic [CHILD_W-1:0]    found_child;
    logic                  found;
    logic [STATUS_W-1:0]   status;
    link_t                 link [0:ENTRIES];

    // Unpack the input transfer.
    assign op          = s_tdata[OP_W-1:0];
    assign key         = s_tdata[OP_W +: KEY_W];
    assign child_value = s_tdata[OP_W + KEY_W +: CHILD_W];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == COUNT_W'(ENTRIES));
    assign ins_en   = accept && (op == OP_INSERT) && !full;

    // Row of slot cells; the leftmost cell sees an empty neighbor.
    assign link[0] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        cell_ctrl_t ctrl;

        assign ctrl.ins_en  = ins_en;
        assign ctrl.chg_en  = accept && (op == OP_CHANGE);
        assign ctrl.valid   = (COUNT_W'(i) < count_reg);
        assign ctrl.at_tail = (COUNT_W'(i) == count_reg);
        assign ctrl.key     = key;
        assign ctrl.value   = child_value;

        sstkt_cell u_cell (
            .clk  (clk),
            .ctrl (ctrl),
            .lin  (link[i]),
            .lout (link[i+1])
        );
    end

    // Result fields and the new entry count.
    always_comb
    begin
        found_child = '0;
        found       = 1'b0;
        status      = ST_OK;
        count_next  = count_reg;
        case (op)
            OP_INSERT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_LOOKUP:
            begin
                found       = link[ENTRIES].hit;
                found_child = link[ENTRIES].hit_child;
            end
            OP_CHANGE:
            begin
                found = link[ENTRIES].hit;
                if (!link[ENTRIES].hit)
                begin
                    status = ST_MISSING;
                end
            end
            default:
            begin
                found = 1'b0;
            end
        endcase
    end

    assign out_data_next = {
        (count_next == COUNT_W'(UNDERFULL_COUNT)),
        (count_next == COUNT_W'(ENTRIES)),
        count_next,
        status,
        found,
        found_child
    };

    // Output register holds the result until it is taken.
    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_data_reg);

endmodule

`default_nettype wire

// ===== rtl/sstkt_checker.sv =====
// Port-level checks of the sorted key table, bound to the top level.
// Depends on sstkt_pkg and sorted_sixteen_entry_key_table_defines.svh.
`default_nettype none

`include "sorted_sixteen_entry_key_table_defines.svh"

module sstkt_checker
    import sstkt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int FOUND_B  = CHILD_W;
    localparam int STATUS_B = FOUND_B + 1;
    localparam int COUNT_B  = STATUS_B + STATUS_W;
    localparam int FULL_B   = COUNT_B + COUNT_W;

    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    assign status = m_tdata[STATUS_B +: STATUS_W];
    assign count  = m_tdata[COUNT_B +: COUNT_W];

    // A stalled result stays put.
    `SSTKT_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Every accepted item yields a result in the next cycle.
    `SSTKT_ASSERT_NEXT(a_result, clk, rst_n, s_tvalid && s_tready, m_tvalid)

    // The count never passes capacity, and the full flag follows it.
    `SSTKT_ASSERT_SAME(a_count, clk, rst_n, m_tvalid,
        (count <= COUNT_W'(ENTRIES)) && (m_tdata[FULL_B] == (count == COUNT_W'(ENTRIES))))

    // A match never comes with an error status.
    `SSTKT_ASSERT_SAME(a_found, clk, rst_n, m_tvalid && m_tdata[FOUND_B], status == ST_OK)

endmodule

bind sorted_sixteen_entry_key_table sstkt_checker u_checker (.*);

`default_nettype wire
